FILE: design/elr_pkg.sv
// Package for the ellipse rasterizer: default widths and queue depth, command codes,
// front sequencer states and the last pixel index per step kind.
// No dependencies.
`timescale 1ns / 1ps

package elr_pkg;

   localparam int COORD_BITS_DEFAULT  = 12;
   localparam int RADIUS_BITS_DEFAULT = 11;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [1:0] ARC_LAST_PIXEL  = 2'd3;
   localparam logic [1:0] TAIL_LAST_PIXEL = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_PRODUCT,
      ST_ERROR,
      ST_ARC,
      ST_TAIL
   } front_state_type;

endpackage

FILE: design/elr_queue.sv
// Short job queue between the front and the back of the ellipse rasterizer.
// Generic width and depth; takes its default depth from elr_pkg.
`timescale 1ns / 1ps

module elr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = elr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   import elr_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/elr_front.sv
// Front of the ellipse rasterizer: accepts commands, runs the start setup and
// the error-term iteration, and pushes one pixel job per step. Uses elr_pkg.
`timescale 1ns / 1ps

module elr_front #(
   parameter int COORD_BITS  = elr_pkg::COORD_BITS_DEFAULT,
   parameter int RADIUS_BITS = elr_pkg::RADIUS_BITS_DEFAULT,
   parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [COORD_BITS-1:0]  req_center_x,
   input  logic [COORD_BITS-1:0]  req_center_y,
   input  logic [RADIUS_BITS-1:0] req_radius_a,
   input  logic [RADIUS_BITS-1:0] req_radius_b,
   output logic                   push,
   output logic [JOB_BITS-1:0]    push_data,
   input  logic                   full
);
   import elr_pkg::*;

   localparam int R        = RADIUS_BITS;
   localparam int ERR_BITS = 3 * R + 5;
   localparam int PROD_BITS = 3 * R + 3;

   front_state_type state_ff, state_in;

   logic [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [R-1:0]          a_ff, a_in, b_ff, b_in;
   logic [R:0]            dx_ff, dx_in;
   logic signed [R:0]     dy_ff, dy_in;
   logic [2*R-1:0]        asq_ff, asq_in, bsq_ff, bsq_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in, tx_ff, tx_in, ty_ff, ty_in;

   logic accept, is_start, init_busy;
   logic signed [R+1:0]         bterm;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [ERR_BITS:0]    e2, neg_ty;
   logic signed [ERR_BITS-1:0]  tx_next, ty_next, add_x, sub_y;
   logic                        move_x, move_y, arc_end, tail_done;
   logic [R:0]                  dx_arc, dx_tail;
   logic signed [R:0]           dy_arc;
   logic                        arc_to_tail;

   assign accept   = req_valid && !req_stall;
   assign is_start = (req_command == CMD_START);

   assign bterm  = {1'b0, b_ff, 1'b0} - {{(R + 1){1'b0}}, 1'b1};
   assign prod   = bterm * $signed({1'b0, asq_ff});
   assign e2     = {err_ff, 1'b0};
   assign neg_ty = -((ERR_BITS + 1)'(ty_ff));
   assign move_x = (e2 < (ERR_BITS + 1)'(tx_ff));
   assign move_y = (e2 > neg_ty);
   assign tx_next = tx_ff + ERR_BITS'({bsq_ff, 1'b0});
   assign ty_next = ty_ff - ERR_BITS'({asq_ff, 1'b0});
   assign add_x  = move_x ? tx_next : '0;
   assign sub_y  = move_y ? ty_next : '0;
   assign dx_arc = dx_ff + (R + 1)'(move_x);
   assign dy_arc = dy_ff - (R + 1)'(move_y);
   assign arc_end     = dy_arc[R] || !(move_x || move_y);
   assign arc_to_tail = (dx_arc < {1'b0, a_ff});
   assign dx_tail     = dx_ff + (R + 1)'(1);
   assign tail_done   = (dx_tail >= {1'b0, a_ff});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SQUARE:  state_in = ST_PRODUCT;
         ST_PRODUCT: state_in = ST_ERROR;
         ST_ERROR:   state_in = ST_ARC;
         ST_IDLE, ST_ARC, ST_TAIL: begin
            if (accept) begin
               if (is_start) begin
                  state_in = ST_SQUARE;
               end else if (state_ff == ST_ARC) begin
                  state_in = arc_end ? (arc_to_tail ? ST_TAIL : ST_IDLE) : ST_ARC;
               end else if (state_ff == ST_TAIL) begin
                  state_in = tail_done ? ST_IDLE : ST_TAIL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      init_busy = (state_ff inside {ST_SQUARE, ST_PRODUCT, ST_ERROR});
      req_stall = init_busy || full;
      push      = accept && !is_start && (state_ff inside {ST_ARC, ST_TAIL});
      if (state_ff == ST_TAIL) begin
         push_data = {tail_done, 1'b1, cx_ff, cy_ff, dx_tail, {R{1'b0}}};
      end else begin
         push_data = {arc_end && !arc_to_tail, 1'b0, cx_ff, cy_ff, dx_ff,
                      dy_ff[R-1:0]};
      end
   end

   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      asq_in = asq_ff;
      bsq_in = bsq_ff;
      err_in = err_ff;
      tx_in  = tx_ff;
      ty_in  = ty_ff;
      case (state_ff)
         ST_SQUARE: begin
            asq_in = a_ff * a_ff;
            bsq_in = b_ff * b_ff;
         end
         ST_PRODUCT: begin
            ty_in = ERR_BITS'(prod);
            tx_in = ERR_BITS'({1'b0, bsq_ff});
         end
         ST_ERROR: begin
            err_in = ERR_BITS'({1'b0, bsq_ff}) - ty_ff;
         end
         default: begin
            if (accept && is_start) begin
               cx_in = req_center_x;
               cy_in = req_center_y;
               a_in  = req_radius_a;
               b_in  = req_radius_b;
               dx_in = '0;
               dy_in = {1'b0, req_radius_b};
            end else if (accept && state_ff == ST_ARC) begin
               dx_in  = dx_arc;
               dy_in  = dy_arc;
               err_in = err_ff + add_x - sub_y;
               if (move_x) begin
                  tx_in = tx_next;
               end
               if (move_y) begin
                  ty_in = ty_next;
               end
            end else if (accept && state_ff == ST_TAIL) begin
               dx_in = dx_tail;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      asq_ff <= asq_in;
      bsq_ff <= bsq_in;
      err_ff <= err_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
   end

endmodule

FILE: design/elr_back.sv
// Back of the ellipse rasterizer: takes pixel jobs from the queue and emits
// their mirrored pixels, one per transfer, through an output register. Uses elr_pkg.
`timescale 1ns / 1ps

module elr_back #(
   parameter int COORD_BITS  = elr_pkg::COORD_BITS_DEFAULT,
   parameter int RADIUS_BITS = elr_pkg::RADIUS_BITS_DEFAULT,
   parameter int JOB_BITS    = 2 * COORD_BITS + 2 * RADIUS_BITS + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_pop,
   input  logic [JOB_BITS-1:0]          job_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic                         rsp_last_of_step,
   output logic                         rsp_ellipse_done
);
   import elr_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int R     = RADIUS_BITS;
   localparam int P     = C + 2;
   localparam int WIDE  = ((C > R + 1) ? C : R + 1) + 2;

   logic [JOB_BITS-1:0] job_ff, job_in;
   logic                have_ff, have_in;
   logic [1:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [P-1:0]        px_ff, px_in, py_ff, py_in;
   logic                last_ff, last_in, done_ff, done_in;

   logic                job_done, job_tail;
   logic [C-1:0]        job_cx, job_cy;
   logic [R:0]          job_dx;
   logic [R-1:0]        job_dy;
   logic                out_load, emit, last, neg_x, neg_y;
   logic [WIDE-1:0]     wx, wy;

   assign {job_done, job_tail, job_cx, job_cy, job_dx, job_dy} = job_ff;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign emit     = out_load && have_ff;
   assign last     = job_tail ? (idx_ff == TAIL_LAST_PIXEL) : (idx_ff == ARC_LAST_PIXEL);
   assign job_pop  = job_valid && (!have_ff || (emit && last));
   assign neg_x    = (idx_ff == 2'd1) || (idx_ff == 2'd2);
   assign neg_y    = (idx_ff == 2'd2) || (idx_ff == 2'd3);

   always_comb begin
      wx = neg_x ? (WIDE'(job_cx) - WIDE'(job_dx)) : (WIDE'(job_cx) + WIDE'(job_dx));
      wy = neg_y ? (WIDE'(job_cy) - WIDE'(job_dy)) : (WIDE'(job_cy) + WIDE'(job_dy));
   end

   always_comb begin
      job_in       = job_pop ? job_data : job_ff;
      have_in      = job_pop ? 1'b1 : ((emit && last) ? 1'b0 : have_ff);
      idx_in       = idx_ff;
      rsp_valid_in = emit ? 1'b1 : (out_load ? 1'b0 : rsp_valid_ff);
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      if (emit) begin
         idx_in  = last ? 2'd0 : idx_ff + 2'd1;
         px_in   = wx[P-1:0];
         py_in   = wy[P-1:0];
         last_in = last;
         done_in = last && job_done;
      end
      if (job_pop) begin
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = px_ff;
   assign rsp_pixel_y      = py_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_ellipse_done = done_ff;

endmodule

FILE: design/ellipse_rasterizer.sv
// The first pixel of a step passes through the job queue, the job register of the
// back and its output register. An arc step gives four pixels, a tail step two,
// through the single result port; steps are taken every cycle while the job
// queue has room. A start is followed by setup states (squares, product, error).
// Reset is synchronous and clears the sequencer, the queue and the output valid.
`timescale 1ns / 1ps

module ellipse_rasterizer #(
   parameter int COORD_BITS  = elr_pkg::COORD_BITS_DEFAULT,
   parameter int RADIUS_BITS = elr_pkg::RADIUS_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]       req_radius_a,
   input  logic [RADIUS_BITS-1:0]       req_radius_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_pixel_x,
   output logic signed [COORD_BITS+1:0] rsp_pixel_y,
   output logic                         rsp_last_of_step,
   output logic                         rsp_ellipse_done
);
   import elr_pkg::*;

   localparam int JOB_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS + 3;

   logic                push, full, q_valid, q_pop;
   logic [JOB_BITS-1:0] push_data, q_data;

   elr_front #(
      .COORD_BITS(COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS),
      .JOB_BITS(JOB_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_center_x(req_center_x),
      .req_center_y(req_center_y),
      .req_radius_a(req_radius_a),
      .req_radius_b(req_radius_b),
      .push(push),
      .push_data(push_data),
      .full(full)
   );

   elr_queue #(
      .WIDTH(JOB_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(full),
      .pop_valid(q_valid),
      .pop(q_pop),
      .pop_data(q_data)
   );

   elr_back #(
      .COORD_BITS(COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS),
      .JOB_BITS(JOB_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(q_valid),
      .job_pop(q_pop),
      .job_data(q_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last_of_step(rsp_last_of_step),
      .rsp_ellipse_done(rsp_ellipse_done)
   );

endmodule

FILE: design/elr_checker.sv
// Port-level assertions for the ellipse rasterizer, bound to the top level.
// Uses elr_pkg for the command codes.
`timescale 1ns / 1ps

module elr_checker #(
   parameter int COORD_BITS  = elr_pkg::COORD_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [COORD_BITS+1:0] rsp_pixel_x,
   input logic signed [COORD_BITS+1:0] rsp_pixel_y,
   input logic                         rsp_last_of_step,
   input logic                         rsp_ellipse_done
);
   import elr_pkg::*;

   // A stalled result must be held unchanged until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last_of_step)
         && $stable(rsp_ellipse_done))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ellipse_done |-> rsp_last_of_step)
      else $error("ellipse end not on last pixel of a step");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A start transfer is followed by setup cycles that hold off new commands.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_START |=> req_stall)
      else $error("command taken during start setup");

endmodule

bind ellipse_rasterizer elr_checker #(
   .COORD_BITS(COORD_BITS)
) u_elr_checker (.*);
